[hdl/btmx_pkg.sv]
package btmx_pkg;

    localparam int ANSWER_W = 32;
    localparam int VALUE_W  = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

[hdl/btmx_ram.sv]
module btmx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/binary_trie_max_xor.sv]
// Binary trie maximum-xor engine.
// Input channel (s_*): s_tuser carries the command (insert, remove, query),
// s_tdata the 32-bit value; only its low KEY_BITS bits are used.
// Output channel (m_*): one transaction per input transaction. m_tdata is the
// largest xor for a query (zero otherwise), m_tuser is set when an insert is
// rejected because the node pool is full.
// Every command walks the trie one level per cycle through a node memory with
// a registered read; the read address of the next level comes from the node
// read in the current one. Query: a single scan pass that ends early at a dead end.
// Insert and remove walk twice (check pass, then read-modify-write pass); an
// early miss shortens the check pass, and a rejected insert or an absent remove
// skips the update pass. An unknown command skips the walk and goes straight
// to the result.
// One command is in flight at a time; the next is accepted once the result has
// entered the output register, even while the receiver stalls it.
// A stalled result holds m_tdata/m_tuser until taken.
// Reset empties the set: the root node lives in flip-flops and is cleared,
// the pool pointer returns to one. No clearing pass is needed; nodes are
// zeroed as they are allocated.
module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = 32,
    parameter int POOL_NODES = 4096,
    parameter int COUNT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // value[31:0]
    input  logic [1:0]          s_tuser,   // command[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ANSWER_W-1:0] m_tdata,   // answer[31:0]
    output logic [0:0]          m_tuser    // status[0]
);

    localparam int IDX_BITS  = $clog2(POOL_NODES);
    localparam int FREE_BITS = $clog2(POOL_NODES + 1);
    localparam int LV_BITS   = $clog2(KEY_BITS);
    localparam int NEED_W    = LV_BITS + 1;
    localparam int NODE_W    = 2 * IDX_BITS + 2 * COUNT_BITS;
    localparam logic [LV_BITS-1:0]    LV_LAST = LV_BITS'(KEY_BITS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   res_reg, res_next;
    logic [LV_BITS-1:0]    lv_reg, lv_next;
    logic [IDX_BITS-1:0]   cur_reg, cur_next;
    logic                  fresh_reg, fresh_next;
    logic [NODE_W-1:0]     root_reg, root_next;
    logic [FREE_BITS-1:0]  next_free_reg, next_free_next;
    logic [KEY_BITS-1:0]   done_answer_reg, done_answer_next;
    logic                  done_status_reg, done_status_next;
    logic [ANSWER_W-1:0]   out_answer_reg, out_answer_next;
    logic                  out_status_reg, out_status_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [NODE_W-1:0]     mem_wdata;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [NODE_W-1:0]     mem_rdata;

    logic [NODE_W-1:0]     node_vec;
    logic [NODE_W-1:0]     node_new;
    logic [IDX_BITS-1:0]   ch [2];
    logic [COUNT_BITS-1:0] cnt [2];
    logic [IDX_BITS-1:0]   ch_new [2];
    logic [COUNT_BITS-1:0] cnt_new [2];
    logic [LV_BITS-1:0]    kidx;
    logic                  kb;
    logic                  lv_first;
    logic                  lv_last;
    logic [NEED_W-1:0]     need;
    logic                  pool_short;
    logic                  opp_ok;
    logic [KEY_BITS-1:0]   res_upd;
    logic [KEY_BITS-1:0]   res_max;

    btmx_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Node seen at the current level: root from flops, freshly allocated
    // nodes as zero, everything else from the memory read issued last cycle.
    always_comb
    begin
        lv_first = (lv_reg == '0);
        lv_last  = (lv_reg == LV_LAST);
        kidx     = LV_LAST - lv_reg;
        kb       = key_reg[kidx];
        if (lv_first)
        begin
            node_vec = root_reg;
        end
        else if (fresh_reg)
        begin
            node_vec = '0;
        end
        else
        begin
            node_vec = mem_rdata;
        end
        ch[0]  = node_vec[IDX_BITS-1:0];
        ch[1]  = node_vec[2*IDX_BITS-1:IDX_BITS];
        cnt[0] = node_vec[2*IDX_BITS+COUNT_BITS-1:2*IDX_BITS];
        cnt[1] = node_vec[NODE_W-1:2*IDX_BITS+COUNT_BITS];

        need       = NEED_W'(KEY_BITS) - NEED_W'(lv_reg);
        pool_short = (({1'b0, next_free_reg} + (FREE_BITS+1)'(need))
                      > (FREE_BITS+1)'(POOL_NODES));

        opp_ok  = (cnt[~kb] != '0) && (ch[~kb] != '0);
        res_upd = res_reg;
        if (opp_ok)
        begin
            res_upd[kidx] = 1'b1;
        end
        res_max = (res_upd > key_reg) ? res_upd : key_reg;

        ch_new  = ch;
        cnt_new = cnt;
        if (cmd_reg == CMD_INSERT)
        begin
            if (ch[kb] == '0)
            begin
                ch_new[kb] = next_free_reg[IDX_BITS-1:0];
            end
            if (cnt[kb] != CNT_MAX)
            begin
                cnt_new[kb] = cnt[kb] + 1'b1;
            end
        end
        else
        begin
            if (cnt[kb] != '0)
            begin
                cnt_new[kb] = cnt[kb] - 1'b1;
            end
        end
        node_new = {cnt_new[1], cnt_new[0], ch_new[1], ch_new[0]};
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        res_next         = res_reg;
        lv_next          = lv_reg;
        cur_next         = cur_reg;
        fresh_next       = fresh_reg;
        root_next        = root_reg;
        next_free_next   = next_free_reg;
        done_answer_next = done_answer_reg;
        done_status_next = done_status_reg;
        out_answer_next  = out_answer_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg;
        mem_wdata        = node_new;
        mem_raddr        = '0;
        s_tready         = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next         = cmd_t'(s_tuser);
                    key_next         = s_tdata[KEY_BITS-1:0];
                    res_next         = '0;
                    lv_next          = '0;
                    cur_next         = '0;
                    fresh_next       = 1'b0;
                    done_answer_next = '0;
                    done_status_next = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_INSERT, CMD_REMOVE, CMD_QUERY: state_next = ST_SCAN;
                        default:                           state_next = ST_DONE;
                    endcase
                end
            end

            ST_SCAN:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if ((ch[kb] == '0) && pool_short)
                        begin
                            done_status_next = 1'b1;
                            state_next       = ST_DONE;
                        end
                        else if ((ch[kb] == '0) || lv_last)
                        begin
                            lv_next    = '0;
                            cur_next   = '0;
                            state_next = ST_MODIFY;
                        end
                        else
                        begin
                            lv_next   = lv_reg + 1'b1;
                            cur_next  = ch[kb];
                            mem_raddr = ch[kb];
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if ((ch[kb] == '0) || (lv_last && (cnt[kb] == '0)))
                        begin
                            state_next = ST_DONE;
                        end
                        else if (lv_last)
                        begin
                            lv_next    = '0;
                            cur_next   = '0;
                            state_next = ST_MODIFY;
                        end
                        else
                        begin
                            lv_next   = lv_reg + 1'b1;
                            cur_next  = ch[kb];
                            mem_raddr = ch[kb];
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (lv_first && (cnt[0] == '0) && (cnt[1] == '0))
                        begin
                            done_answer_next = key_reg;
                            state_next       = ST_DONE;
                        end
                        else if (!opp_ok && (ch[kb] == '0))
                        begin
                            // dead end: the remaining low bits stay zero
                            done_answer_next = res_max;
                            state_next       = ST_DONE;
                        end
                        else if (lv_last)
                        begin
                            done_answer_next = res_max;
                            state_next       = ST_DONE;
                        end
                        else
                        begin
                            res_next  = res_upd;
                            lv_next   = lv_reg + 1'b1;
                            cur_next  = opp_ok ? ch[~kb] : ch[kb];
                            mem_raddr = opp_ok ? ch[~kb] : ch[kb];
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_MODIFY:
            begin
                if (lv_first)
                begin
                    root_next = node_new;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                if ((cmd_reg == CMD_INSERT) && (ch[kb] == '0))
                begin
                    next_free_next = next_free_reg + 1'b1;
                    fresh_next     = 1'b1;
                end
                else
                begin
                    fresh_next = 1'b0;
                end
                if (lv_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lv_next   = lv_reg + 1'b1;
                    cur_next  = ch_new[kb];
                    mem_raddr = ch_new[kb];
                end
            end

            ST_DONE:
            begin
                // hand over only when the output register is free or draining
                if (!out_valid_reg || m_tready)
                begin
                    out_answer_next = ANSWER_W'(done_answer_reg);
                    out_status_next = done_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            root_reg      <= '0;
            next_free_reg <= FREE_BITS'(1);
            out_valid_reg <= 1'b0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        res_reg         <= res_next;
        lv_reg          <= lv_next;
        cur_reg         <= cur_next;
        done_answer_reg <= done_answer_next;
        done_status_reg <= done_status_next;
        out_answer_reg  <= out_answer_next;
        out_status_reg  <= out_status_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_answer_reg;
    assign m_tuser[0] = out_status_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= FREE_BITS'(POOL_NODES))
        else $error("node pool pointer past end of pool");

    a_root_in_flops: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr != '0))
        else $error("root node written to memory");

    a_read_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_MODIFY))
        |-> ({1'b0, mem_raddr} < (IDX_BITS+1)'(POOL_NODES)))
        else $error("node read outside pool");

    a_reject_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && done_status_reg) |-> (cmd_reg == CMD_INSERT))
        else $error("pool-full status on a non-insert command");

    a_pool_grows_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |-> ($past(state_reg) == ST_MODIFY))
        else $error("pool pointer moved outside an insert update");

endmodule
